/* rtl/ucbd_pkg.sv */
// Package for the UART command byte decoder: character codes,
// detector phase encodings and the frame detector result bundle.
// No dependencies.
package ucbd_pkg;

  // Command characters
  localparam logic [7:0] CH_HEAD = 8'h23;  // '#'
  localparam logic [7:0] CH_TAIL = 8'h21;  // '!'
  localparam logic [7:0] CH_QUES = 8'h3F;  // '?'
  localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
  localparam logic [7:0] CH_DASH = 8'h2D;  // '-'
  localparam logic [7:0] CH_LPAR = 8'h28;  // '('
  localparam logic [7:0] CH_RPAR = 8'h29;  // ')'
  localparam logic [7:0] CH_LO   = 8'h6F;  // 'o'
  localparam logic [7:0] CH_LW   = 8'h77;  // 'w'

  // Frame detector phases
  typedef enum logic [1:0] {
    FRM_WAIT_HEAD = 2'd0,
    FRM_TAKE_ONE  = 2'd1,
    FRM_TAKE_TWO  = 2'd2,
    FRM_WAIT_TAIL = 2'd3
  } frame_phase_t;

  // Stop detector phases
  typedef enum logic [1:0] {
    STOP_IDLE     = 2'd0,
    STOP_SEEN_Q   = 2'd1,
    STOP_SEEN_QS  = 2'd2,
    STOP_LATCHED  = 2'd3
  } stop_phase_t;

  // Two-byte arm, third-byte fire detector phases
  typedef enum logic [1:0] {
    ARM_IDLE       = 2'd0,
    ARM_SEEN_FIRST = 2'd1,
    ARM_ARMED      = 2'd2
  } arm_phase_t;

  // Frame detector outputs, state after the current byte
  typedef struct packed {
    logic [7:0] motor_one;
    logic [7:0] motor_two;
    logic       frame_closed;
  } frame_res_t;

endpackage

/* rtl/ucbd_if.sv */
// Valid/ready channel interfaces for the UART command byte decoder.
// Request carries one received byte, result carries the decoded outputs.
interface ucbd_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] motor_one;
  logic [7:0] motor_two;
  logic       frame_closed;
  logic       stop_request;
  logic       enc_clear;
  logic       pins_clear;

  modport source (output valid, output motor_one, output motor_two,
                  output frame_closed, output stop_request,
                  output enc_clear, output pins_clear, input ready);
  modport sink   (input valid, input motor_one, input motor_two,
                  input frame_closed, input stop_request,
                  input enc_clear, input pins_clear, output ready);
endinterface

/* rtl/ucbd_frame_det.sv */
// Frame detector: '#', two payload bytes, then wait for '!'.
// Depends on ucbd_pkg.
module ucbd_frame_det (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  output ucbd_pkg::frame_res_t  res
);

  ucbd_pkg::frame_phase_t phase, phase_next;
  logic [7:0] payload_one, payload_one_next;
  logic [7:0] payload_two, payload_two_next;

  // Next state
  always_comb begin
    phase_next       = phase;
    payload_one_next = payload_one;
    payload_two_next = payload_two;
    case (phase)
      ucbd_pkg::FRM_WAIT_HEAD: begin
        if (rx_byte == ucbd_pkg::CH_HEAD) phase_next = ucbd_pkg::FRM_TAKE_ONE;
      end
      ucbd_pkg::FRM_TAKE_ONE: begin
        payload_one_next = rx_byte;
        phase_next       = ucbd_pkg::FRM_TAKE_TWO;
      end
      ucbd_pkg::FRM_TAKE_TWO: begin
        payload_two_next = rx_byte;
        phase_next       = ucbd_pkg::FRM_WAIT_TAIL;
      end
      ucbd_pkg::FRM_WAIT_TAIL: begin
        if (rx_byte == ucbd_pkg::CH_TAIL) phase_next = ucbd_pkg::FRM_WAIT_HEAD;
      end
      default: phase_next = ucbd_pkg::FRM_WAIT_HEAD;
    endcase
  end

  // Outputs reflect the state after this byte
  always_comb begin
    res.motor_one    = payload_one_next;
    res.motor_two    = payload_two_next;
    res.frame_closed = (phase == ucbd_pkg::FRM_WAIT_TAIL) &&
                       (rx_byte == ucbd_pkg::CH_TAIL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ucbd_pkg::FRM_WAIT_HEAD;
      payload_one <= 8'd0;
      payload_two <= 8'd0;
    end else if (take) begin
      phase       <= phase_next;
      payload_one <= payload_one_next;
      payload_two <= payload_two_next;
    end
  end

endmodule

/* rtl/ucbd_stop_det.sv */
// Stop detector: '?','*','-' latches a sticky stop request until reset.
// Depends on ucbd_pkg.
module ucbd_stop_det (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       stop_request
);

  ucbd_pkg::stop_phase_t phase, phase_next;

  // Next state; a wrong byte mid-sequence drops back to idle
  always_comb begin
    phase_next = phase;
    case (phase)
      ucbd_pkg::STOP_IDLE: begin
        if (rx_byte == ucbd_pkg::CH_QUES) phase_next = ucbd_pkg::STOP_SEEN_Q;
      end
      ucbd_pkg::STOP_SEEN_Q: begin
        phase_next = (rx_byte == ucbd_pkg::CH_STAR) ? ucbd_pkg::STOP_SEEN_QS
                                                    : ucbd_pkg::STOP_IDLE;
      end
      ucbd_pkg::STOP_SEEN_QS: begin
        phase_next = (rx_byte == ucbd_pkg::CH_DASH) ? ucbd_pkg::STOP_LATCHED
                                                    : ucbd_pkg::STOP_IDLE;
      end
      ucbd_pkg::STOP_LATCHED: phase_next = ucbd_pkg::STOP_LATCHED;
      default:                phase_next = ucbd_pkg::STOP_IDLE;
    endcase
  end

  // Output
  always_comb begin
    stop_request = (phase_next == ucbd_pkg::STOP_LATCHED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ucbd_pkg::STOP_IDLE;
    end else if (take) begin
      phase <= phase_next;
    end
  end

endmodule

/* rtl/ucbd_arm_det.sv */
// Arm-and-fire detector: two bytes arm it, a third byte fires a pulse.
// Used for encoder clear and pin clear. Depends on ucbd_pkg.
module ucbd_arm_det (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic [7:0] first_char,
  input  logic [7:0] second_char,
  input  logic [7:0] fire_char,
  output logic       pulse
);

  ucbd_pkg::arm_phase_t phase, phase_next;

  // Next state; once armed, other bytes are ignored
  always_comb begin
    phase_next = ucbd_pkg::ARM_IDLE;
    case (phase)
      ucbd_pkg::ARM_SEEN_FIRST: begin
        phase_next = (rx_byte == second_char) ? ucbd_pkg::ARM_ARMED
                                              : ucbd_pkg::ARM_IDLE;
      end
      ucbd_pkg::ARM_ARMED: begin
        phase_next = (rx_byte == fire_char) ? ucbd_pkg::ARM_IDLE
                                            : ucbd_pkg::ARM_ARMED;
      end
      default: begin
        phase_next = (rx_byte == first_char) ? ucbd_pkg::ARM_SEEN_FIRST
                                             : ucbd_pkg::ARM_IDLE;
      end
    endcase
  end

  // Output
  always_comb begin
    pulse = (phase == ucbd_pkg::ARM_ARMED) && (rx_byte == fire_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ucbd_pkg::ARM_IDLE;
    end else if (take) begin
      phase <= phase_next;
    end
  end

endmodule

/* rtl/uart_command_byte_decoder_unit.sv */
// UART command byte decoder, top level. An accepted byte's result is
// loaded into the output register in the next cycle. Throughput: one byte per cycle;
// a new byte is taken whenever the output register is empty or being drained.
// Reset (rst, synchronous): all detectors idle, payloads 0, stop cleared,
// no result pending. Depends on ucbd_pkg, ucbd_if and the detector modules.
module uart_command_byte_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  ucbd_req_if.sink    req,
  ucbd_rsp_if.source  rsp
);

  logic                 take;
  ucbd_pkg::frame_res_t frame_res;
  logic                 stop_now;
  logic                 enc_now;
  logic                 pin_now;

  logic                 res_valid;
  ucbd_pkg::frame_res_t res_frame;
  logic                 res_stop;
  logic                 res_enc;
  logic                 res_pin;

  // Handshake: output register frees up when empty or taken this cycle
  assign req.ready = !res_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  // Detectors
  ucbd_frame_det u_frame (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (req.rx_byte),
    .res     (frame_res)
  );

  ucbd_stop_det u_stop (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rx_byte      (req.rx_byte),
    .stop_request (stop_now)
  );

  ucbd_arm_det u_enc (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (req.rx_byte),
    .first_char  (ucbd_pkg::CH_LPAR),
    .second_char (ucbd_pkg::CH_DASH),
    .fire_char   (ucbd_pkg::CH_RPAR),
    .pulse       (enc_now)
  );

  ucbd_arm_det u_pin (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (req.rx_byte),
    .first_char  (ucbd_pkg::CH_LO),
    .second_char (ucbd_pkg::CH_LW),
    .fire_char   (ucbd_pkg::CH_LO),
    .pulse       (pin_now)
  );

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_frame <= frame_res;
      res_stop  <= stop_now;
      res_enc   <= enc_now;
      res_pin   <= pin_now;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.motor_one     = res_frame.motor_one;
  assign rsp.motor_two     = res_frame.motor_two;
  assign rsp.frame_closed  = res_frame.frame_closed;
  assign rsp.stop_request  = res_stop;
  assign rsp.enc_clear     = res_enc;
  assign rsp.pins_clear    = res_pin;

  // Stop request never drops once reported
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.stop_request) |=> rsp.stop_request)
    else $error("stop request dropped after being reported");

  // A single byte closes at most one command kind
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot0({rsp.frame_closed, rsp.enc_clear, rsp.pins_clear}))
    else $error("more than one completion pulse on one byte");

  // Every accepted byte produces a pending result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp.valid)
    else $error("accepted byte produced no result");

  // Empty output register never blocks the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req.ready)
    else $error("input stalled with empty output register");

endmodule
